// ===== rtl/atrp_pkg.sv =====
// Package: shared types, keyword table and constants of the AT response byte parser.
package atrp_pkg;

    // Major parser states; ST_KW walks the keyword table with a separate position counter.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CR,
        ST_LF,
        ST_ADDR,
        ST_LINK,
        ST_COMMA,
        ST_LEN,
        ST_DATA,
        ST_PROMPT,
        ST_KW
    } parse_state_t;

    typedef enum logic [2:0] {
        RESP_OK       = 3'd0,
        RESP_ERROR    = 3'd1,
        RESP_NOCHANGE = 3'd2,
        RESP_FAIL     = 3'd3,
        RESP_READY    = 3'd4,
        RESP_GOTIP    = 3'd5,
        RESP_SEND     = 3'd6,
        RESP_NONE     = 3'd7
    } resp_code_t;

    localparam int KW_CHARS = 48;
    localparam int KW_POS_W = 6;
    typedef logic [KW_POS_W-1:0] kw_pos_t;

    // All keywords back to back, first character in the top byte.
    localparam logic [8*KW_CHARS-1:0] KW_TEXT =
        "OKERRORno changeFAILreadyWIFI GOT IPSTAIP,\"+IPD,";

    // Start position of each keyword in the table.
    localparam kw_pos_t KW_START_OK       = 6'd0;
    localparam kw_pos_t KW_START_ERROR    = 6'd2;
    localparam kw_pos_t KW_START_NOCHANGE = 6'd7;
    localparam kw_pos_t KW_START_FAIL     = 6'd16;
    localparam kw_pos_t KW_START_READY    = 6'd20;
    localparam kw_pos_t KW_START_GOTIP    = 6'd25;
    localparam kw_pos_t KW_START_STAIP    = 6'd36;
    localparam kw_pos_t KW_START_IPD      = 6'd43;

    // Last position of each keyword in the table.
    localparam kw_pos_t KW_END_OK       = 6'd1;
    localparam kw_pos_t KW_END_ERROR    = 6'd6;
    localparam kw_pos_t KW_END_NOCHANGE = 6'd15;
    localparam kw_pos_t KW_END_FAIL     = 6'd19;
    localparam kw_pos_t KW_END_READY    = 6'd24;
    localparam kw_pos_t KW_END_GOTIP    = 6'd35;
    localparam kw_pos_t KW_END_STAIP    = 6'd42;
    localparam kw_pos_t KW_END_IPD      = 6'd47;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PROMPT = 8'h3E;

    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_N_LC = 8'h6E;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_R_LC = 8'h72;
    localparam logic [7:0] CH_W    = 8'h57;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_PLUS = 8'h2B;

    // One result transaction.
    typedef struct packed {
        logic       resp_valid;
        logic [2:0] resp_code;
        logic [7:0] link_id;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [3:0] payload_index;
        logic       msg_done;
        logic       msg_drop;
        logic [3:0] msg_length;
        logic       ip_valid;
        logic [7:0] ip_byte;
        logic [3:0] ip_index;
    } result_t;

    function automatic logic [7:0] kw_char(input kw_pos_t pos);
        logic [7:0] ch;
        ch = KW_TEXT[8*(KW_CHARS-1-int'(pos)) +: 8];
        return ch;
    endfunction

endpackage

// ===== rtl/atrp_parser.sv =====
// Parser state machine: per-byte next state and result of the AT response parser.
module atrp_parser #(
    parameter int PAYLOAD_MAX = 16,
    parameter int ADDR_MAX    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    output atrp_pkg::result_t res
);

    localparam int IDX_MAX = (PAYLOAD_MAX - 1 > ADDR_MAX) ? PAYLOAD_MAX - 1 : ADDR_MAX;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam logic [IDX_W-1:0] ADDR_LIMIT = IDX_W'(ADDR_MAX);
    localparam logic [IDX_W-1:0] PAY_LAST   = IDX_W'(PAYLOAD_MAX - 1);

    atrp_pkg::parse_state_t state_reg, state_next;
    atrp_pkg::resp_code_t   pending_reg, pending_next;
    atrp_pkg::kw_pos_t      kw_pos_reg, kw_pos_next;
    logic [IDX_W-1:0]       index_reg, index_next;
    logic [7:0]             link_reg, link_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= atrp_pkg::ST_IDLE;
            pending_reg <= atrp_pkg::RESP_NONE;
            kw_pos_reg  <= '0;
            index_reg   <= '0;
            link_reg    <= '0;
        end else if (step_en) begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            kw_pos_reg  <= kw_pos_next;
            index_reg   <= index_next;
            link_reg    <= link_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        kw_pos_next  = kw_pos_reg;
        index_next   = index_reg;
        link_next    = link_reg;
        res          = '0;

        case (state_reg)
            atrp_pkg::ST_IDLE: begin
                pending_next = atrp_pkg::RESP_NONE;
                state_next   = atrp_pkg::ST_KW;
                case (rx_byte)
                    atrp_pkg::CH_PROMPT: state_next  = atrp_pkg::ST_PROMPT;
                    atrp_pkg::CH_O:      kw_pos_next = atrp_pkg::KW_START_OK + 6'd1;
                    atrp_pkg::CH_E:      kw_pos_next = atrp_pkg::KW_START_ERROR + 6'd1;
                    atrp_pkg::CH_N_LC:   kw_pos_next = atrp_pkg::KW_START_NOCHANGE + 6'd1;
                    atrp_pkg::CH_F:      kw_pos_next = atrp_pkg::KW_START_FAIL + 6'd1;
                    atrp_pkg::CH_R_LC:   kw_pos_next = atrp_pkg::KW_START_READY + 6'd1;
                    atrp_pkg::CH_W:      kw_pos_next = atrp_pkg::KW_START_GOTIP + 6'd1;
                    atrp_pkg::CH_S:      kw_pos_next = atrp_pkg::KW_START_STAIP + 6'd1;
                    atrp_pkg::CH_PLUS:   kw_pos_next = atrp_pkg::KW_START_IPD + 6'd1;
                    default:             state_next  = atrp_pkg::ST_IDLE;
                endcase
            end
            atrp_pkg::ST_KW: begin
                state_next = atrp_pkg::ST_IDLE;
                if (int'(kw_pos_reg) < atrp_pkg::KW_CHARS &&
                    rx_byte == atrp_pkg::kw_char(kw_pos_reg)) begin
                    state_next = atrp_pkg::ST_CR;
                    case (kw_pos_reg)
                        atrp_pkg::KW_END_OK:       pending_next = atrp_pkg::RESP_OK;
                        atrp_pkg::KW_END_ERROR:    pending_next = atrp_pkg::RESP_ERROR;
                        atrp_pkg::KW_END_NOCHANGE: pending_next = atrp_pkg::RESP_NOCHANGE;
                        atrp_pkg::KW_END_FAIL:     pending_next = atrp_pkg::RESP_FAIL;
                        atrp_pkg::KW_END_READY:    pending_next = atrp_pkg::RESP_READY;
                        atrp_pkg::KW_END_GOTIP:    pending_next = atrp_pkg::RESP_GOTIP;
                        atrp_pkg::KW_END_STAIP: begin
                            index_next = '0;
                            state_next = atrp_pkg::ST_ADDR;
                        end
                        atrp_pkg::KW_END_IPD:      state_next = atrp_pkg::ST_LINK;
                        default: begin
                            kw_pos_next = kw_pos_reg + 6'd1;
                            state_next  = atrp_pkg::ST_KW;
                        end
                    endcase
                end
            end
            atrp_pkg::ST_CR: begin
                state_next = (rx_byte == atrp_pkg::CH_CR) ? atrp_pkg::ST_LF : atrp_pkg::ST_IDLE;
            end
            atrp_pkg::ST_LF: begin
                if (rx_byte == atrp_pkg::CH_LF && pending_reg != atrp_pkg::RESP_NONE) begin
                    res.resp_valid = 1'b1;
                    res.resp_code  = pending_reg;
                end
                state_next = atrp_pkg::ST_IDLE;
            end
            atrp_pkg::ST_PROMPT: begin
                res.resp_valid = 1'b1;
                res.resp_code  = atrp_pkg::RESP_SEND;
                state_next     = atrp_pkg::ST_IDLE;
            end
            atrp_pkg::ST_ADDR: begin
                if (rx_byte == atrp_pkg::CH_QUOTE) begin
                    pending_next = atrp_pkg::RESP_OK;
                    state_next   = atrp_pkg::ST_LF;
                end else if (index_reg < ADDR_LIMIT) begin
                    res.ip_valid = 1'b1;
                    res.ip_byte  = rx_byte;
                    res.ip_index = 4'(index_reg);
                    index_next   = index_reg + IDX_W'(1);
                end
            end
            atrp_pkg::ST_LINK: begin
                link_next  = rx_byte;
                state_next = atrp_pkg::ST_COMMA;
            end
            atrp_pkg::ST_COMMA: begin
                if (rx_byte == atrp_pkg::CH_COMMA) begin
                    state_next = atrp_pkg::ST_LEN;
                    index_next = '0;
                end else begin
                    state_next = atrp_pkg::ST_IDLE;
                end
            end
            atrp_pkg::ST_LEN: begin
                if (rx_byte == atrp_pkg::CH_COLON) begin
                    state_next = atrp_pkg::ST_DATA;
                end
                index_next = '0;
            end
            atrp_pkg::ST_DATA: begin
                if (rx_byte == atrp_pkg::CH_CR && index_reg != '0) begin
                    res.msg_done   = 1'b1;
                    res.msg_length = 4'(index_reg);
                    index_next     = '0;
                    state_next     = atrp_pkg::ST_IDLE;
                end else if ((rx_byte == atrp_pkg::CH_CR || rx_byte == atrp_pkg::CH_LF) &&
                             index_reg == '0) begin
                    state_next = atrp_pkg::ST_IDLE;
                end else if (index_reg >= PAY_LAST) begin
                    res.msg_drop = 1'b1;
                    index_next   = '0;
                    state_next   = atrp_pkg::ST_IDLE;
                end else begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = rx_byte;
                    res.payload_index = 4'(index_reg);
                    index_next        = index_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = atrp_pkg::ST_IDLE;
            end
        endcase

        res.link_id = link_next;
    end

endmodule

// ===== rtl/at_response_byte_parser_unit.sv =====
// Top level: AT response byte parser with stream handshake and result register.
// Output: a result transaction is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parser state and the result register update
// together, and a byte is taken whenever the result register is empty or drained.
// Reset: aresetn (synchronous, active low) returns the parser to idle with no
// pending response, a zero link id and an empty result register.
module at_response_byte_parser_unit #(
    parameter int PAYLOAD_MAX = 16,
    parameter int ADDR_MAX    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Byte input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] resp_valid, [3:1] resp_code, [11:4] link_id, [12] payload_valid,
    // [20:13] payload_byte, [24:21] payload_index, [25] msg_done, [26] msg_drop,
    // [30:27] msg_length, [31] ip_valid, [39:32] ip_byte, [43:40] ip_index,
    // [47:44] zero
    output logic [47:0] m_tdata
);

    logic              step_en;
    atrp_pkg::result_t step_res;
    atrp_pkg::result_t res_reg;
    logic              m_tvalid_reg;

    // Take a byte whenever the result register is free or being drained this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;

    // Parser state machine: advance on every accepted transaction.
    atrp_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .ADDR_MAX    (ADDR_MAX)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_byte (s_tdata),
        .res     (step_res)
    );

    // Result register: load on accept, drop valid once the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; hold it while stalled.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Pack fields from the lowest bit up.
    assign m_tdata[0]     = res_reg.resp_valid;
    assign m_tdata[3:1]   = res_reg.resp_code;
    assign m_tdata[11:4]  = res_reg.link_id;
    assign m_tdata[12]    = res_reg.payload_valid;
    assign m_tdata[20:13] = res_reg.payload_byte;
    assign m_tdata[24:21] = res_reg.payload_index;
    assign m_tdata[25]    = res_reg.msg_done;
    assign m_tdata[26]    = res_reg.msg_drop;
    assign m_tdata[30:27] = res_reg.msg_length;
    assign m_tdata[31]    = res_reg.ip_valid;
    assign m_tdata[39:32] = res_reg.ip_byte;
    assign m_tdata[43:40] = res_reg.ip_index;
    assign m_tdata[47:44] = 4'd0;

endmodule

// ===== tb/tb_at_response_byte_parser_unit.sv =====
// Testbench for the AT response byte parser: random modem traffic checked against a predictor.
module tb_at_response_byte_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_LIMIT  = 16;
    localparam int ADDR_LIMIT     = 16;
    localparam int RANDOM_BYTES   = 1700;
    localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the parser
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    // Markers in the byte queue; real bytes are 0..255.
    localparam int MARK_PAUSE = -1;  // hold the sender until every result is back
    localparam int MARK_HOLD  = -2;  // ask the receiver for one long hold-off

    // Keyword indexes beyond the six response keywords.
    localparam int KW_IDX_STAIP = 6;
    localparam int KW_IDX_IPD   = 7;
    localparam int KW_NUM       = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    at_response_byte_parser_unit #(
        .PAYLOAD_MAX(PAYLOAD_LIMIT),
        .ADDR_MAX   (ADDR_LIMIT)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),    // [7:0] rx_byte
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)     // [0] resp_valid ... [43:40] ip_index, [47:44] zero
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: parser state kept in the testbench, advanced per byte.
    // ------------------------------------------------------------------
    string keyword_text = "OKERRORno changeFAILreadyWIFI GOT IPSTAIP,\"+IPD,";
    atrp_pkg::kw_pos_t kw_first [KW_NUM] = '{
        atrp_pkg::KW_START_OK, atrp_pkg::KW_START_ERROR, atrp_pkg::KW_START_NOCHANGE,
        atrp_pkg::KW_START_FAIL, atrp_pkg::KW_START_READY, atrp_pkg::KW_START_GOTIP,
        atrp_pkg::KW_START_STAIP, atrp_pkg::KW_START_IPD};
    atrp_pkg::kw_pos_t kw_last  [KW_NUM] = '{
        atrp_pkg::KW_END_OK, atrp_pkg::KW_END_ERROR, atrp_pkg::KW_END_NOCHANGE,
        atrp_pkg::KW_END_FAIL, atrp_pkg::KW_END_READY, atrp_pkg::KW_END_GOTIP,
        atrp_pkg::KW_END_STAIP, atrp_pkg::KW_END_IPD};
    atrp_pkg::resp_code_t kw_code [6] = '{
        atrp_pkg::RESP_OK, atrp_pkg::RESP_ERROR, atrp_pkg::RESP_NOCHANGE,
        atrp_pkg::RESP_FAIL, atrp_pkg::RESP_READY, atrp_pkg::RESP_GOTIP};
    string kw_words [KW_NUM] = '{"OK", "ERROR", "no change", "FAIL", "ready",
                                 "WIFI GOT IP", "STAIP,\"", "+IPD,"};

    atrp_pkg::parse_state_t prs_state    = atrp_pkg::ST_IDLE;
    int                     kw_cursor    = 0;
    atrp_pkg::resp_code_t   pending_code = atrp_pkg::RESP_NONE;
    int                     char_count   = 0;
    logic [7:0]             link_latch   = 8'd0;

    // Advance the predicted parser by one byte and return the result it posts.
    function automatic atrp_pkg::result_t parse_byte(input logic [7:0] b);
        atrp_pkg::result_t r;
        int      k;
        int      pos;
        bit      found;
        r = '0;
        found = 1'b0;
        case (prs_state)
            atrp_pkg::ST_IDLE: begin
                pending_code = atrp_pkg::RESP_NONE;
                if (b == atrp_pkg::CH_PROMPT) begin
                    prs_state = atrp_pkg::ST_PROMPT;
                end else begin
                    for (k = 0; k < KW_NUM; k++) begin
                        if (b == keyword_text[kw_first[k]]) begin
                            prs_state = atrp_pkg::ST_KW;
                            kw_cursor = int'(kw_first[k]) + 1;
                        end
                    end
                end
            end
            atrp_pkg::ST_CR: begin
                prs_state = (b == atrp_pkg::CH_CR) ? atrp_pkg::ST_LF : atrp_pkg::ST_IDLE;
            end
            atrp_pkg::ST_LF: begin
                if (b == atrp_pkg::CH_LF && pending_code != atrp_pkg::RESP_NONE) begin
                    r.resp_valid = 1'b1;
                    r.resp_code  = pending_code;
                end
                prs_state = atrp_pkg::ST_IDLE;
            end
            atrp_pkg::ST_PROMPT: begin
                // whatever follows the prompt posts the send code unparsed
                r.resp_valid = 1'b1;
                r.resp_code  = atrp_pkg::RESP_SEND;
                prs_state    = atrp_pkg::ST_IDLE;
            end
            atrp_pkg::ST_ADDR: begin
                if (b == atrp_pkg::CH_QUOTE) begin
                    pending_code = atrp_pkg::RESP_OK;
                    prs_state    = atrp_pkg::ST_LF;
                end else if (char_count < ADDR_LIMIT) begin
                    r.ip_valid = 1'b1;
                    r.ip_byte  = b;
                    r.ip_index = 4'(char_count);
                    char_count++;
                end
            end
            atrp_pkg::ST_LINK: begin
                link_latch = b;
                prs_state  = atrp_pkg::ST_COMMA;
            end
            atrp_pkg::ST_COMMA: begin
                if (b == atrp_pkg::CH_COMMA) begin
                    prs_state  = atrp_pkg::ST_LEN;
                    char_count = 0;
                end else begin
                    prs_state = atrp_pkg::ST_IDLE;
                end
            end
            atrp_pkg::ST_LEN: begin
                if (b == atrp_pkg::CH_COLON) prs_state = atrp_pkg::ST_DATA;
                char_count = 0;
            end
            atrp_pkg::ST_DATA: begin
                if (b == atrp_pkg::CH_CR && char_count != 0) begin
                    r.msg_done   = 1'b1;
                    r.msg_length = 4'(char_count);
                    char_count   = 0;
                    prs_state    = atrp_pkg::ST_IDLE;
                end else if ((b == atrp_pkg::CH_CR || b == atrp_pkg::CH_LF) &&
                             char_count == 0) begin
                    prs_state = atrp_pkg::ST_IDLE;
                end else if (char_count + 1 >= PAYLOAD_LIMIT) begin
                    r.msg_drop = 1'b1;
                    char_count = 0;
                    prs_state  = atrp_pkg::ST_IDLE;
                end else begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = 4'(char_count);
                    char_count++;
                end
            end
            atrp_pkg::ST_KW: begin
                pos = kw_cursor;
                prs_state = atrp_pkg::ST_IDLE;
                if (pos < atrp_pkg::KW_CHARS && b == keyword_text[pos]) begin
                    for (k = 0; k < KW_NUM; k++) begin
                        if (!found && pos >= kw_first[k] && pos <= kw_last[k]) begin
                            found = 1'b1;
                            if (pos < kw_last[k]) begin
                                prs_state = atrp_pkg::ST_KW;
                                kw_cursor = pos + 1;
                            end else if (k < KW_IDX_STAIP) begin
                                pending_code = kw_code[k];
                                prs_state    = atrp_pkg::ST_CR;
                            end else if (k == KW_IDX_STAIP) begin
                                char_count = 0;
                                prs_state  = atrp_pkg::ST_ADDR;
                            end else begin
                                prs_state = atrp_pkg::ST_LINK;
                            end
                        end
                    end
                end
            end
            default: prs_state = atrp_pkg::ST_IDLE;
        endcase
        r.link_id = link_latch;
        return r;
    endfunction

    function automatic atrp_pkg::result_t unpack_result(input logic [47:0] d);
        atrp_pkg::result_t r;
        r.resp_valid    = d[0];
        r.resp_code     = d[3:1];
        r.link_id       = d[11:4];
        r.payload_valid = d[12];
        r.payload_byte  = d[20:13];
        r.payload_index = d[24:21];
        r.msg_done      = d[25];
        r.msg_drop      = d[26];
        r.msg_length    = d[30:27];
        r.ip_valid      = d[31];
        r.ip_byte       = d[39:32];
        r.ip_index      = d[43:40];
        return r;
    endfunction

    // Names of the fields that differ; empty when the transaction matches.
    function automatic string field_diffs(input atrp_pkg::result_t e,
                                          input atrp_pkg::result_t a,
                                          input logic [3:0] pad);
        string s;
        s = "";
        if (e.resp_valid    !== a.resp_valid)    s = {s, " resp_valid"};
        if (e.resp_code     !== a.resp_code)     s = {s, " resp_code"};
        if (e.link_id       !== a.link_id)       s = {s, " link_id"};
        if (e.payload_valid !== a.payload_valid) s = {s, " payload_valid"};
        if (e.payload_byte  !== a.payload_byte)  s = {s, " payload_byte"};
        if (e.payload_index !== a.payload_index) s = {s, " payload_index"};
        if (e.msg_done      !== a.msg_done)      s = {s, " msg_done"};
        if (e.msg_drop      !== a.msg_drop)      s = {s, " msg_drop"};
        if (e.msg_length    !== a.msg_length)    s = {s, " msg_length"};
        if (e.ip_valid      !== a.ip_valid)      s = {s, " ip_valid"};
        if (e.ip_byte       !== a.ip_byte)       s = {s, " ip_byte"};
        if (e.ip_index      !== a.ip_index)      s = {s, " ip_index"};
        if (pad             !== 4'd0)            s = {s, " padding"};
        return s;
    endfunction

    function automatic string show(input atrp_pkg::result_t r);
        return $sformatf(
            "resp %b/%0d link %h pay %b/%h/%0d done %b drop %b len %0d ip %b/%h/%0d",
            r.resp_valid, r.resp_code, r.link_id, r.payload_valid,
            r.payload_byte, r.payload_index, r.msg_done, r.msg_drop,
            r.msg_length, r.ip_valid, r.ip_byte, r.ip_index);
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long one.
    function automatic int pick_gap(input bit gappy);
        int roll;
        if (!gappy) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: bytes and markers queued up front, consumed by the driver.
    // ------------------------------------------------------------------
    int rx_bytes [$];

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) rx_bytes.push_back(int'(s[i]));
    endtask

    // One random chunk of modem traffic: mostly well-formed replies, some broken.
    task automatic add_random_sequence();
        int kind;
        int variant;
        int n;
        int c;
        string w;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            w = kw_words[$urandom_range(0, 5)];
            variant = $urandom_range(0, 9);
            if (variant <= 6) begin
                push_text(w);
                push_text("\r\n");
            end else if (variant == 7) begin
                push_text(w);
                rx_bytes.push_back(atrp_pkg::CH_CR);
                rx_bytes.push_back($urandom_range(0, 255));
            end else if (variant == 8) begin
                push_text(w);
                rx_bytes.push_back($urandom_range(0, 255));
            end else begin
                // broken keyword: a prefix, then a random byte
                push_text(w.substr(0, $urandom_range(0, w.len() - 2)));
                rx_bytes.push_back($urandom_range(0, 255));
            end
        end else if (kind < 40) begin
            rx_bytes.push_back(atrp_pkg::CH_PROMPT);
            rx_bytes.push_back($urandom_range(0, 255));
        end else if (kind < 58) begin
            push_text(kw_words[KW_IDX_STAIP]);
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(16, 22);
            for (int i = 0; i < n; i++) begin
                do c = $urandom_range(0, 255); while (c == atrp_pkg::CH_QUOTE);
                rx_bytes.push_back(c);
            end
            rx_bytes.push_back(atrp_pkg::CH_QUOTE);
            rx_bytes.push_back(($urandom_range(0, 9) < 8) ? int'(atrp_pkg::CH_LF)
                                                          : $urandom_range(0, 255));
        end else if (kind < 90) begin
            push_text(kw_words[KW_IDX_IPD]);
            rx_bytes.push_back($urandom_range(0, 255));
            if ($urandom_range(0, 9) < 9) begin
                rx_bytes.push_back(atrp_pkg::CH_COMMA);
            end else begin
                do c = $urandom_range(0, 255); while (c == atrp_pkg::CH_COMMA);
                rx_bytes.push_back(c);
            end
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) rx_bytes.push_back($urandom_range(8'h30, 8'h39));
            rx_bytes.push_back(atrp_pkg::CH_COLON);
            variant = $urandom_range(0, 99);
            if (variant < 5) begin
                // empty message: CR or LF right after the colon
                rx_bytes.push_back(($urandom_range(0, 1) == 1) ? int'(atrp_pkg::CH_CR)
                                                               : int'(atrp_pkg::CH_LF));
            end else begin
                n = (variant < 88) ? $urandom_range(1, 14) : $urandom_range(15, 18);
                for (int i = 0; i < n; i++) begin
                    do c = $urandom_range(0, 255);
                    while (c == atrp_pkg::CH_CR || (i == 0 && c == atrp_pkg::CH_LF));
                    rx_bytes.push_back(c);
                end
                rx_bytes.push_back(atrp_pkg::CH_CR);
            end
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) rx_bytes.push_back($urandom_range(0, 255));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver, monitor and watchdog.
    // ------------------------------------------------------------------
    atrp_pkg::result_t expected_results [$];

    bit   byte_taken    = 1'b0;
    bit   result_taken  = 1'b0;
    bit   tx_gappy      = 1'b1;
    bit   rx_gappy      = 1'b1;
    int   tx_gap        = 0;
    int   rx_gap        = 0;
    int   hold_left     = 0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   stall_cycles  = 0;
    logic next_valid;
    logic [7:0] next_data;
    logic next_ready;

    int bytes_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int responses     = 0;
    int prompts       = 0;
    int payload_bytes = 0;
    int messages      = 0;
    int drops         = 0;
    int ip_chars      = 0;
    int pauses        = 0;

    // Sender: advance to the next byte once the current one is taken (or none is up).
    always @(negedge aclk) begin
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            next_valid = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (rx_bytes.size() > 0) begin
                if (rx_bytes[0] == MARK_HOLD) begin
                    void'(rx_bytes.pop_front());
                    hold_requests <= hold_requests + 1;
                end
                if (rx_bytes.size() > 0 && rx_bytes[0] == MARK_PAUSE) begin
                    // drain the parser completely before going on
                    if (expected_results.size() == 0) begin
                        void'(rx_bytes.pop_front());
                        pauses++;
                    end
                end else if (rx_bytes.size() > 0) begin
                    next_valid = 1'b1;
                    next_data  = 8'(rx_bytes.pop_front());
                    if ($urandom_range(0, 149) == 0) tx_gappy = !tx_gappy;
                    tx_gap = pick_gap(tx_gappy);
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // Receiver: random back-pressure plus the requested long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            next_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left  = LONG_HOLD;
            next_ready = 1'b0;
        end else begin
            if (result_taken) begin
                if ($urandom_range(0, 119) == 0) rx_gappy = !rx_gappy;
                rx_gap = pick_gap(rx_gappy);
            end
            if (rx_gap > 0) begin
                rx_gap--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
        end
        m_tready <= next_ready;
    end

    // Monitor: predict on every accepted byte, check every accepted result.
    always @(posedge aclk) begin
        byte_taken   = aresetn && s_tvalid && s_tready;
        result_taken = aresetn && m_tvalid && m_tready;
        if (byte_taken) begin
            expected_results.push_back(parse_byte(s_tdata));
            bytes_sent++;
        end
        if (result_taken) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: result %0d arrived with nothing expected: %s",
                             results_seen, show(unpack_result(m_tdata)));
            end else begin
                atrp_pkg::result_t want;
                string             diffs;
                want  = expected_results.pop_front();
                diffs = field_diffs(want, unpack_result(m_tdata), m_tdata[47:44]);
                if (diffs != "") begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("ERROR: result %0d differs in%s", results_seen, diffs);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(unpack_result(m_tdata)));
                    end
                end
                if (want.resp_valid) begin
                    responses++;
                    if (want.resp_code == atrp_pkg::RESP_SEND) prompts++;
                end
                if (want.payload_valid) payload_bytes++;
                if (want.msg_done) messages++;
                if (want.msg_drop) drops++;
                if (want.ip_valid) ip_chars++;
            end
        end
        // watchdog: count cycles in which neither side moves a transaction
        if (aresetn && !byte_taken && !result_taken) stall_cycles++;
        else stall_cycles = 0;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, run, drain, report.
    // ------------------------------------------------------------------
    initial begin
        int since_pause;
        since_pause = 0;

        // directed: response with CR LF, prompt with an all-ones byte,
        // keyword followed by CR but no LF, mismatch inside a keyword,
        // an all-zero byte, and an empty data message
        push_text("OK\r\n");
        rx_bytes.push_back(atrp_pkg::CH_PROMPT);
        rx_bytes.push_back(8'hFF);
        push_text("FAIL\rX");
        push_text("OE");
        rx_bytes.push_back(8'h00);
        push_text("+IPD,0,1:\r");

        // drain, then back the parser up against a long receiver hold-off
        rx_bytes.push_back(MARK_PAUSE);
        rx_bytes.push_back(MARK_HOLD);

        while (rx_bytes.size() < RANDOM_BYTES + 30) begin
            add_random_sequence();
            since_pause++;
            if (since_pause == 60) begin
                rx_bytes.push_back(MARK_PAUSE);
                since_pause = 0;
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (rx_bytes.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d bytes, %0d results, %0d mismatches, %0d pauses, %0d long holds",
                 bytes_sent, results_seen, mismatches, pauses, holds_served);
        $display("Seen: %0d resp (%0d prompt), %0d payload, %0d msg, %0d drop, %0d addr",
                 responses, prompts, payload_bytes, messages, drops, ip_chars);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
